// File: design/bft_pkg.sv
// bft_pkg: shared types, codes and defaults for the breadth-first traversal unit
// used by every module of the block but bft_ram; depends on nothing
`default_nettype none

package bft_pkg;

    // default sizes of the graph storage
    localparam int BFT_VERTEX_COUNT = 64;
    localparam int BFT_MAX_DEGREE   = 8;

    // fixed field widths of the item and result beats
    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;

    // item opcodes
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_TRAVERSE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_VISITED = 2'd2;

    typedef struct packed {
        logic                opcode;
        logic [VERTEX_W-1:0] source_vertex;
        logic [VERTEX_W-1:0] target_vertex;
    } bft_item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] visited_vertex;
        logic [STATUS_W-1:0] status;
        logic                last;
    } bft_result_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ADD_DONE,
        S_VIS_CLR,
        S_SEED,
        S_POP,
        S_VERTEX,
        S_DEGREE,
        S_NB_READ,
        S_NB_DATA,
        S_NB_CHECK,
        S_EMIT
    } bft_state_t;

    // controller to datapath
    typedef struct packed {
        logic ld_item;
        logic cnt_clear;
        logic cnt_inc;
        logic deg_wr_zero;
        logic vis_wr_zero;
        logic deg_rd_src;
        logic add_commit;
        logic emit_add;
        logic seed;
        logic q_rd;
        logic ld_v;
        logic ld_deg;
        logic nb_rd;
        logic vis_rd;
        logic vis_commit;
        logic emit_vis;
    } bft_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_last;
        logic is_traverse;
        logic start_ok;
        logic add_ok;
        logic nb_done;
        logic q_empty;
        logic out_free;
    } bft_sts_t;

endpackage

`default_nettype wire

// File: design/bft_ram.sv
// bft_ram: generic single-write, single-read memory with registered read data
// no package dependency
`default_nettype none

module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/bft_ctrl.sv
// bft_ctrl: sequencing state machine of the traversal unit
// depends on bft_pkg (state enum, command and status structs)
`default_nettype none

module bft_ctrl import bft_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  bft_sts_t sts,
    output bft_cmd_t cmd
);

    bft_state_t state_reg;
    bft_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                // zero the degree counts, one vertex a cycle
                cmd.deg_wr_zero = 1'b1;
                cmd.cnt_inc     = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.deg_rd_src = 1'b1;
                cmd.cnt_clear  = 1'b1;
                if (!sts.is_traverse)
                begin
                    state_next = S_ADD_DONE;
                end
                else if (sts.start_ok)
                begin
                    state_next = S_VIS_CLR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ADD_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_add   = 1'b1;
                    cmd.add_commit = sts.add_ok;
                    state_next     = S_IDLE;
                end
            end
            S_VIS_CLR:
            begin
                // wipe visited marks before the walk
                cmd.vis_wr_zero = 1'b1;
                cmd.cnt_inc     = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.q_rd   = 1'b1;
                state_next = S_VERTEX;
            end
            S_VERTEX:
            begin
                cmd.ld_v   = 1'b1;
                state_next = S_DEGREE;
            end
            S_DEGREE:
            begin
                cmd.ld_deg = 1'b1;
                state_next = S_NB_READ;
            end
            S_NB_READ:
            begin
                if (sts.nb_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.nb_rd  = 1'b1;
                    state_next = S_NB_DATA;
                end
            end
            S_NB_DATA:
            begin
                cmd.vis_rd = 1'b1;
                state_next = S_NB_CHECK;
            end
            S_NB_CHECK:
            begin
                cmd.vis_commit = 1'b1;
                state_next     = S_NB_READ;
            end
            S_EMIT:
            begin
                // vertex goes out once its neighbors are queued, so last is known
                if (sts.out_free)
                begin
                    cmd.emit_vis = 1'b1;
                    state_next   = sts.q_empty ? S_IDLE : S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/bft_dp.sv
// bft_dp: datapath of the traversal unit: neighbor, degree, visited and queue
// memories, pointers and the result register; depends on bft_pkg and bft_ram
`default_nettype none

module bft_dp import bft_pkg::*; #(
    parameter int VERTEX_COUNT = BFT_VERTEX_COUNT,
    parameter int MAX_DEGREE   = BFT_MAX_DEGREE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  bft_item_t   item,
    output bft_result_t result,
    output logic        result_valid,
    input  logic        result_stall,
    input  bft_cmd_t    cmd,
    output bft_sts_t    sts
);

    localparam int VW = $clog2(VERTEX_COUNT);
    localparam int QW = $clog2(VERTEX_COUNT + 1);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int NB_DEPTH = VERTEX_COUNT * MAX_DEGREE;
    localparam int AW = (NB_DEPTH > 1) ? $clog2(NB_DEPTH) : 1;

    // latched item
    logic               op_reg;
    logic [VERTEX_W-1:0] src_reg;
    logic [VERTEX_W-1:0] dst_reg;
    // sweep counter, current vertex, degree and neighbor slot
    logic [VW-1:0]      cnt_reg, cnt_next;
    logic [VW-1:0]      v_reg;
    logic [DW-1:0]      deg_reg;
    logic [DW-1:0]      idx_reg, idx_next;
    // queue pointers
    logic [QW-1:0]      head_reg, head_next;
    logic [QW-1:0]      tail_reg, tail_next;
    // result register
    logic               out_valid_reg, out_valid_next;
    bft_result_t        out_reg;

    logic [VW-1:0]      src_idx;
    logic               src_ok;
    logic               dst_ok;
    logic               add_ok;
    logic               q_empty;
    logic               out_free;
    logic               enqueue;

    logic               deg_wr_en;
    logic [VW-1:0]      deg_wr_addr;
    logic [DW-1:0]      deg_wr_data;
    logic [VW-1:0]      deg_rd_addr;
    logic [DW-1:0]      deg_rdata;

    logic [AW-1:0]      nb_wr_addr;
    logic [AW-1:0]      nb_rd_addr;
    logic [VW-1:0]      nb_rdata;

    logic               vis_wr_en;
    logic [VW-1:0]      vis_wr_addr;
    logic               vis_rdata;

    logic [VW-1:0]      q_wr_addr;
    logic [VW-1:0]      q_wr_data;
    logic [VW-1:0]      q_rdata;

    // range checks and flags
    assign src_idx  = VW'(src_reg);
    assign src_ok   = 32'(src_reg) < VERTEX_COUNT;
    assign dst_ok   = 32'(dst_reg) < VERTEX_COUNT;
    assign add_ok   = src_ok && dst_ok && (deg_rdata != DW'(MAX_DEGREE));
    assign q_empty  = head_reg == tail_reg;
    assign out_free = !out_valid_reg || !result_stall;
    // stored edges are range checked on entry, so only the mark matters here
    assign enqueue  = cmd.vis_commit && !vis_rdata;

    assign sts.cnt_last    = cnt_reg == VW'(VERTEX_COUNT - 1);
    assign sts.is_traverse = op_reg == OP_TRAVERSE;
    assign sts.start_ok    = src_ok;
    assign sts.add_ok      = add_ok;
    assign sts.nb_done     = idx_reg == deg_reg;
    assign sts.q_empty     = q_empty;
    assign sts.out_free    = out_free;

    // degree counts
    assign deg_wr_en   = cmd.deg_wr_zero || cmd.add_commit;
    assign deg_wr_addr = cmd.deg_wr_zero ? cnt_reg : src_idx;
    assign deg_wr_data = cmd.deg_wr_zero ? '0 : DW'(deg_rdata + 1'b1);
    assign deg_rd_addr = cmd.deg_rd_src ? src_idx : q_rdata;

    bft_ram #(.WIDTH(DW), .DEPTH(VERTEX_COUNT)) u_deg_ram (
        .clk     (clk),
        .wr_en   (deg_wr_en),
        .wr_addr (deg_wr_addr),
        .wr_data (deg_wr_data),
        .rd_en   (cmd.deg_rd_src || cmd.ld_v),
        .rd_addr (deg_rd_addr),
        .rd_data (deg_rdata)
    );

    // neighbor lists, one row of MAX_DEGREE slots per vertex
    assign nb_wr_addr = AW'(AW'(src_idx) * AW'(MAX_DEGREE)) + AW'(deg_rdata);
    assign nb_rd_addr = AW'(AW'(v_reg) * AW'(MAX_DEGREE)) + AW'(idx_reg);

    bft_ram #(.WIDTH(VW), .DEPTH(NB_DEPTH)) u_nb_ram (
        .clk     (clk),
        .wr_en   (cmd.add_commit),
        .wr_addr (nb_wr_addr),
        .wr_data (VW'(dst_reg)),
        .rd_en   (cmd.nb_rd),
        .rd_addr (nb_rd_addr),
        .rd_data (nb_rdata)
    );

    // visited marks
    assign vis_wr_en   = cmd.vis_wr_zero || cmd.seed || enqueue;
    assign vis_wr_addr = cmd.vis_wr_zero ? cnt_reg : (cmd.seed ? src_idx : nb_rdata);

    bft_ram #(.WIDTH(1), .DEPTH(VERTEX_COUNT)) u_vis_ram (
        .clk     (clk),
        .wr_en   (vis_wr_en),
        .wr_addr (vis_wr_addr),
        .wr_data (!cmd.vis_wr_zero),
        .rd_en   (cmd.vis_rd),
        .rd_addr (nb_rdata),
        .rd_data (vis_rdata)
    );

    // pending vertex queue
    assign q_wr_addr = cmd.seed ? '0 : tail_reg[VW-1:0];
    assign q_wr_data = cmd.seed ? src_idx : nb_rdata;

    bft_ram #(.WIDTH(VW), .DEPTH(VERTEX_COUNT)) u_queue_ram (
        .clk     (clk),
        .wr_en   (cmd.seed || enqueue),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (cmd.q_rd),
        .rd_addr (head_reg[VW-1:0]),
        .rd_data (q_rdata)
    );

    // counter and pointer next values
    always_comb
    begin
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = VW'(cnt_reg + 1'b1);
        end
        if (cmd.ld_deg)
        begin
            idx_next = '0;
        end
        else if (cmd.vis_commit)
        begin
            idx_next = DW'(idx_reg + 1'b1);
        end
        if (cmd.seed)
        begin
            head_next = '0;
            tail_next = QW'(1);
        end
        else
        begin
            if (cmd.q_rd)
            begin
                head_next = QW'(head_reg + 1'b1);
            end
            if (enqueue)
            begin
                tail_next = QW'(tail_reg + 1'b1);
            end
        end
    end

    // result valid next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_add || cmd.emit_vis)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            op_reg  <= item.opcode;
            src_reg <= item.source_vertex;
            dst_reg <= item.target_vertex;
        end
        if (cmd.ld_v)
        begin
            v_reg <= q_rdata;
        end
        if (cmd.ld_deg)
        begin
            deg_reg <= deg_rdata;
        end
        idx_reg <= idx_next;
        if (cmd.emit_add)
        begin
            out_reg.visited_vertex <= '0;
            out_reg.status         <= add_ok ? STATUS_STORED : STATUS_DROPPED;
            out_reg.last           <= 1'b1;
        end
        else if (cmd.emit_vis)
        begin
            out_reg.visited_vertex <= VERTEX_W'(v_reg);
            out_reg.status         <= STATUS_VISITED;
            out_reg.last           <= q_empty;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: design/breadth_first_traversal_unit.sv
// Breadth-first traversal unit. After reset the block holds item_stall high
// while it zeroes the per-vertex degree counts. An add-edge item then
// yields one beat (stored or dropped). A traverse item first wipes the
// visited marks one vertex a cycle, then for each visited vertex pops the
// queue and loads the vertex and its degree, and for each outgoing edge
// reads the neighbor and then its visited mark: the neighbor and
// visited-mark memories, each with a single read port, are read one after
// the other for every edge. One beat per visited vertex, the last one marked.
// Results sit in an output register, so the next vertex is expanded while a
// beat waits; the walk holds at the next emit until the waiting beat leaves.
// top level: joins bft_ctrl and bft_dp; depends on bft_pkg
`default_nettype none

module breadth_first_traversal_unit import bft_pkg::*; #(
    parameter int VERTEX_COUNT = BFT_VERTEX_COUNT,
    parameter int MAX_DEGREE   = BFT_MAX_DEGREE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  bft_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output bft_result_t result
);

    bft_cmd_t cmd;
    bft_sts_t sts;

    // sequencer
    bft_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // memories, pointers and result register
    bft_dp #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

// File: design/bft_checker.sv
// bft_checker: port-level checks of the traversal unit, bound to the top level
// depends on bft_pkg (beat structs, status codes)
`default_nettype none

module bft_checker import bft_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input bft_result_t result
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // the block works on one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted while previous item still in flight");

    // edge acknowledgements carry vertex zero and close their item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == STATUS_STORED || result.status == STATUS_DROPPED)
        |-> result.last && (result.visited_vertex == '0))
        else $error("malformed edge acknowledgement");

    // no status code beyond visited
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status == STATUS_STORED || result.status == STATUS_DROPPED
            || result.status == STATUS_VISITED)
        else $error("unknown result status");

endmodule

bind breadth_first_traversal_unit bft_checker u_bft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
